// ===== sv/csw_pkg.sv =====
`default_nettype none

package csw_pkg;

    // Request codes carried in the req_type field.
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_UNMAPPED = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_CHANGED  = 3'd4;
    localparam logic [2:0] ST_SAME     = 3'd5;

    // Fixed read values.
    localparam logic [7:0] REVISION_VALUE = 8'h01;
    localparam logic [7:0] UNMAPPED_VALUE = 8'hFF;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_DEVICE_ID    = 3'd0;
    localparam logic [2:0] REG_ADDR_DEV_ID  = 3'd1;
    localparam logic [2:0] REG_ADDR_HW_REV  = 3'd2;
    localparam logic [2:0] REG_ADDR_SW_REV  = 3'd3;
    localparam logic [2:0] REG_ADDR_CELL    = 3'd4;
    localparam logic [2:0] REG_CELL_DEFAULT = 3'd5;

    // Register reset values.
    localparam logic [7:0] RST_DEVICE_ID    = 8'd0;
    localparam logic [7:0] RST_ADDR_DEV_ID  = 8'd0;
    localparam logic [7:0] RST_ADDR_HW_REV  = 8'd1;
    localparam logic [7:0] RST_ADDR_SW_REV  = 8'd2;
    localparam logic [7:0] RST_ADDR_CELL    = 8'd16;
    localparam logic [7:0] RST_CELL_DEFAULT = 8'd255;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] address;
        logic [7:0] write_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] status;
    } t_out_word;

    // One buffered write.
    typedef struct packed {
        logic [7:0] address;
        logic [7:0] value;
    } t_entry;

    // Configuration register contents.
    typedef struct packed {
        logic [7:0] device_id;
        logic [7:0] addr_device_id;
        logic [7:0] addr_hw_revision;
        logic [7:0] addr_sw_revision;
        logic [7:0] addr_stored_cell;
        logic [7:0] cell_default;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/csw_ram.sv =====
`default_nettype none

module csw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/csw_cfg.sv =====
`default_nettype none

module csw_cfg
    import csw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready,
    output      t_cfg                  o_cfg,
    output      logic                  o_seed
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;
    logic [7:0] wr_byte;
    logic [7:0] rd_byte;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite & pready;
    assign wr_byte = pwdata[7:0];

    // Register writes; anything beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_id        <= RST_DEVICE_ID;
            r_cfg.addr_device_id   <= RST_ADDR_DEV_ID;
            r_cfg.addr_hw_revision <= RST_ADDR_HW_REV;
            r_cfg.addr_sw_revision <= RST_ADDR_SW_REV;
            r_cfg.addr_stored_cell <= RST_ADDR_CELL;
            r_cfg.cell_default     <= RST_CELL_DEFAULT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DEVICE_ID:    r_cfg.device_id        <= wr_byte;
                REG_ADDR_DEV_ID:  r_cfg.addr_device_id   <= wr_byte;
                REG_ADDR_HW_REV:  r_cfg.addr_hw_revision <= wr_byte;
                REG_ADDR_SW_REV:  r_cfg.addr_sw_revision <= wr_byte;
                REG_ADDR_CELL:    r_cfg.addr_stored_cell <= wr_byte;
                REG_CELL_DEFAULT: r_cfg.cell_default     <= wr_byte;
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        case (reg_idx)
            REG_DEVICE_ID:    rd_byte = r_cfg.device_id;
            REG_ADDR_DEV_ID:  rd_byte = r_cfg.addr_device_id;
            REG_ADDR_HW_REV:  rd_byte = r_cfg.addr_hw_revision;
            REG_ADDR_SW_REV:  rd_byte = r_cfg.addr_sw_revision;
            REG_ADDR_CELL:    rd_byte = r_cfg.addr_stored_cell;
            REG_CELL_DEFAULT: rd_byte = r_cfg.cell_default;
            default:          rd_byte = 8'd0;
        endcase
    end

    assign prdata = {{(APB_DATA_W-8){1'b0}}, rd_byte};
    assign o_cfg  = r_cfg;

    // Writing the default value also reseeds the persistent cell.
    assign o_seed = wr_en && (reg_idx == REG_CELL_DEFAULT);

endmodule

`default_nettype wire

// ===== sv/config_store_write_buffer.sv =====
// Configuration store with a ring write buffer in front of one persistent cell.
// Requests arrive on the input channel (i_in_valid / o_in_stall) as one word
// holding req_type, address and write_value; each request gives exactly one
// result word on the output channel (o_out_valid / i_out_stall).
// The block handles one request at a time and stalls its input until the
// result has been taken. Path from acceptance to result valid:
//   write, unknown request, read of a special address: straight to the result
//   flush: S_FL_RD, one read of the buffer RAM at the head, then S_FL_CMP
//     (empty ring: straight to the result)
//   read of a buffered or ordinary address: S_SCAN over the n buffered entries
//     (at most QUEUE_DEPTH-1); the scan compares one RAM entry per cycle.
// A new request is accepted the cycle after the result is taken.
// Write the registers through the APB-style port only while the block is idle;
// the block does not enforce it. Reset empties the ring, loads the registers
// with their reset values and seeds the cell with the default value. While the
// receiver stalls, the result word holds and no new request is accepted.
`default_nettype none

module config_store_write_buffer
    import csw_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output      logic                  o_in_stall,
    input  wire t_in_word              i_in_word,
    output      logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    output      t_out_word             o_out_word,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FL_RD,
        S_FL_CMP,
        S_RESP
    } t_state;

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
        ring_next = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    t_state        r_state;
    logic [IW-1:0] r_head;
    logic [IW-1:0] r_tail;
    logic [IW-1:0] r_ptr;
    logic [IW-1:0] r_left;
    logic          r_vld;
    logic          r_hit;
    logic [7:0]    r_hdata;
    logic [7:0]    r_addr;
    logic [7:0]    r_cell;
    t_out_word     r_out;

    t_cfg          cfg;
    logic          seed;
    t_entry        wr_entry;
    t_entry        rd_entry;
    logic          in_acc;
    logic          ram_we;
    logic          ring_full;
    logic          ring_empty;
    logic          wr_mapped;
    logic [IW:0]   fill_diff;
    logic [IW:0]   fill_cnt;

    csw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_seed  (seed)
    );

    // Ring storage: written at the tail, read at the scan pointer.
    csw_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (wr_entry),
        .i_raddr (r_ptr),
        .o_rdata (rd_entry)
    );

    // Handshake and ring status.
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == S_RESP);
    assign o_out_word  = r_out;

    assign ring_full  = (ring_next(r_tail) == r_head);
    assign ring_empty = (r_head == r_tail);
    assign wr_mapped  = (i_in_word.address == cfg.addr_stored_cell);
    assign ram_we     = in_acc && (i_in_word.req_type == REQ_WRITE) && wr_mapped && !ring_full;

    assign wr_entry.address = i_in_word.address;
    assign wr_entry.value   = i_in_word.write_value;

    // Number of buffered entries, head to tail around the ring.
    assign fill_diff = {1'b0, r_tail} - {1'b0, r_head};
    assign fill_cnt  = (r_tail < r_head) ? fill_diff + (IW+1)'(QUEUE_DEPTH) : fill_diff;

    // Sequencer: state, ring pointers, cell and result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_cell  <= RST_CELL_DEFAULT;
            r_vld   <= 1'b0;
        end else begin
            if (seed) begin
                r_cell <= pwdata[7:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_out.read_data <= 8'd0;
                        r_out.status    <= ST_DONE;
                        r_state         <= S_RESP;
                        case (i_in_word.req_type)
                            REQ_READ: begin
                                if (i_in_word.address == cfg.addr_device_id) begin
                                    r_out.read_data <= cfg.device_id;
                                end else if (i_in_word.address == cfg.addr_hw_revision ||
                                             i_in_word.address == cfg.addr_sw_revision) begin
                                    r_out.read_data <= REVISION_VALUE;
                                end else begin
                                    r_ptr   <= r_head;
                                    r_left  <= fill_cnt[IW-1:0];
                                    r_vld   <= 1'b0;
                                    r_hit   <= 1'b0;
                                    r_addr  <= i_in_word.address;
                                    r_state <= S_SCAN;
                                end
                            end
                            REQ_WRITE: begin
                                if (!wr_mapped) begin
                                    r_out.status <= ST_UNMAPPED;
                                end else if (ring_full) begin
                                    r_out.status <= ST_FULL;
                                end else begin
                                    r_tail <= ring_next(r_tail);
                                end
                            end
                            REQ_FLUSH: begin
                                if (ring_empty) begin
                                    r_out.status <= ST_EMPTY;
                                end else begin
                                    r_ptr   <= r_head;
                                    r_state <= S_FL_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    // Oldest to newest, so the last hit is the newest value.
                    if (r_vld && rd_entry.address == r_addr) begin
                        r_hit   <= 1'b1;
                        r_hdata <= rd_entry.value;
                    end
                    r_vld <= (r_left != '0);
                    if (r_left != '0) begin
                        r_ptr  <= ring_next(r_ptr);
                        r_left <= r_left - 1'b1;
                    end else if (!r_vld) begin
                        if (r_hit) begin
                            r_out.read_data <= r_hdata;
                        end else if (r_addr == cfg.addr_stored_cell) begin
                            r_out.read_data <= r_cell;
                        end else begin
                            r_out.read_data <= UNMAPPED_VALUE;
                        end
                        r_state <= S_RESP;
                    end
                end
                S_FL_RD: begin
                    r_state <= S_FL_CMP;
                end
                S_FL_CMP: begin
                    // Drain the oldest entry; skip the cell write when unmapped or unchanged.
                    if (rd_entry.address == cfg.addr_stored_cell &&
                        rd_entry.value != r_cell) begin
                        r_cell       <= rd_entry.value;
                        r_out.status <= ST_CHANGED;
                    end else begin
                        r_out.status <= ST_SAME;
                    end
                    r_head  <= ring_next(r_head);
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The head moves only when a flush drains an entry.
    a_head_on_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head != $past(r_head)) |-> ($past(r_state) == S_FL_CMP))
        else $error("ring head moved outside a flush");

    // The tail moves only on an accepted write.
    a_tail_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tail != $past(r_tail)) |-> $past(ram_we))
        else $error("ring tail moved without a buffered write");

    // No request is taken while a result waits.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while a result is pending");

    // A buffered write never fills the last ring slot.
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_head != r_tail))
        else $error("ring wrapped onto its head");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import csw_pkg::*;

    localparam int RING_DEPTH   = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1150;
    localparam int PHASES       = 8;
    localparam int REPORT_LIMIT = 10;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    // A request word together with the response word predicted for it.
    typedef struct packed {
        t_in_word  req;
        t_out_word resp;
    } t_pending;

    // Scoreboard: mirrors the registers, the write ring and the cell, and
    // keeps the predicted response words in order.
    class cfg_store_checker;
        logic [7:0] device_id;
        logic [7:0] addr_dev_id;
        logic [7:0] addr_hw_rev;
        logic [7:0] addr_sw_rev;
        logic [7:0] addr_cell;
        logic [7:0] cell_default;
        logic [7:0] ring_addr  [RING_DEPTH];
        logic [7:0] ring_value [RING_DEPTH];
        int         head;
        int         tail;
        logic [7:0] cell_byte;
        t_pending   expected_responses[$];
        int         mismatches;

        function new();
            device_id    = RST_DEVICE_ID;
            addr_dev_id  = RST_ADDR_DEV_ID;
            addr_hw_rev  = RST_ADDR_HW_REV;
            addr_sw_rev  = RST_ADDR_SW_REV;
            addr_cell    = RST_ADDR_CELL;
            cell_default = RST_CELL_DEFAULT;
            cell_byte    = RST_CELL_DEFAULT;
            head         = 0;
            tail         = 0;
            mismatches   = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] value);
            case (idx)
                REG_DEVICE_ID:   device_id   = value;
                REG_ADDR_DEV_ID: addr_dev_id = value;
                REG_ADDR_HW_REV: addr_hw_rev = value;
                REG_ADDR_SW_REV: addr_sw_rev = value;
                REG_ADDR_CELL:   addr_cell   = value;
                REG_CELL_DEFAULT: begin
                    // A new default also reseeds the cell.
                    cell_default = value;
                    cell_byte    = value;
                end
                default: ;
            endcase
        endfunction

        // Special addresses first, then the newest buffered entry, then the cell.
        function logic [7:0] read_byte(logic [7:0] a);
            logic [7:0] data;
            bit         hit;
            int         i;
            if (a == addr_dev_id) return device_id;
            if (a == addr_hw_rev) return REVISION_VALUE;
            if (a == addr_sw_rev) return REVISION_VALUE;
            hit  = 1'b0;
            data = UNMAPPED_VALUE;
            for (i = head; i != tail; i = (i + 1) % RING_DEPTH) begin
                if (ring_addr[i] == a) begin
                    data = ring_value[i];
                    hit  = 1'b1;
                end
            end
            if (!hit && a == addr_cell) data = cell_byte;
            return data;
        endfunction

        function t_out_word predict_response(t_in_word w);
            t_out_word r;
            int        nxt;
            r.read_data = 8'h00;
            r.status    = ST_DONE;
            case (w.req_type)
                REQ_READ: r.read_data = read_byte(w.address);
                REQ_WRITE: begin
                    nxt = (tail + 1) % RING_DEPTH;
                    if (w.address != addr_cell) begin
                        r.status = ST_UNMAPPED;
                    end else if (nxt == head) begin
                        r.status = ST_FULL;
                    end else begin
                        ring_addr[tail]  = w.address;
                        ring_value[tail] = w.write_value;
                        tail             = nxt;
                    end
                end
                REQ_FLUSH: begin
                    if (head == tail) begin
                        r.status = ST_EMPTY;
                    end else begin
                        // An entry whose address is no longer mapped is dropped.
                        if (ring_addr[head] == addr_cell && cell_byte != ring_value[head]) begin
                            cell_byte = ring_value[head];
                            r.status  = ST_CHANGED;
                        end else begin
                            r.status = ST_SAME;
                        end
                        head = (head + 1) % RING_DEPTH;
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_request(t_in_word w);
            t_pending p;
            p.req  = w;
            p.resp = predict_response(w);
            expected_responses.push_back(p);
        endfunction

        function void check_response(t_out_word got);
            t_pending p;
            if (expected_responses.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected response word: data %h status %0d",
                             got.read_data, got.status);
                return;
            end
            p = expected_responses.pop_front();
            if (got.read_data !== p.resp.read_data || got.status !== p.resp.status) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"mismatch: req %0d addr %h val %h: ",
                              "expected data %h status %0d, got data %h status %0d"},
                             p.req.req_type, p.req.address, p.req.write_value,
                             p.resp.read_data, p.resp.status, got.read_data, got.status);
            end
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_word             o_out_word;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cfg_store_checker sb;
    bit               hold_req = 1'b0;

    config_store_write_buffer #(
        .QUEUE_DEPTH(RING_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_in_word make_word(logic [1:0] t, logic [7:0] a, logic [7:0] v);
        t_in_word w;
        w.req_type    = t;
        w.address     = a;
        w.write_value = v;
        return w;
    endfunction

    // Offer one request word and hold it until the block takes it.
    task automatic send_request(t_in_word w);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_word  = w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(w);
    endtask

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
    endtask

    // Stop sending and wait until every predicted response has arrived.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(logic [2:0] idx, logic [7:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {24'h0, value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Response monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_response(o_out_word);
    end

    // Receiver stall pattern, with one long hold-off on request.
    initial begin : receiver
        int mode;
        int span;
        int n;
        i_out_stall = 1'b0;
        mode        = 0;
        span        = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req    = 1'b0;
                i_out_stall = 1'b1;
                for (n = 1; n < HOLD_CYCLES; n++) @(negedge i_clk);
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(8, 64);
                end
                span--;
                case (mode)
                    0:       i_out_stall = 1'b0;
                    1:       i_out_stall = 1'($urandom_range(0, 1));
                    2:       i_out_stall = ($urandom_range(0, 3) != 0);
                    default: i_out_stall = (span % 3 == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int         phase;
        int         r;
        int         sent;
        int         burst;
        int         k;
        int         pick;
        int         sel;
        bit         quiet;
        logic [7:0] prev_cell;
        logic [7:0] shared;
        logic [7:0] vals [6];
        t_in_word   w;

        sb         = new();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: special reads, unmapped access, filling the ring, flushes.
        write_reg(REG_DEVICE_ID, 8'hA5);
        send_request(make_word(REQ_READ, 8'h00, 8'h00));
        send_request(make_word(REQ_READ, 8'h01, 8'h00));
        send_request(make_word(REQ_READ, 8'h02, 8'h00));
        send_request(make_word(REQ_READ, 8'h10, 8'h00));
        send_request(make_word(REQ_READ, 8'hFF, 8'hFF));
        send_request(make_word(REQ_FLUSH, 8'h00, 8'h00));
        send_request(make_word(REQ_WRITE, 8'hFF, 8'h3C));
        send_request(make_word(REQ_WRITE, 8'h10, 8'h00));
        send_request(make_word(REQ_WRITE, 8'h10, 8'hFF));
        send_request(make_word(REQ_WRITE, 8'h10, 8'h5A));
        send_request(make_word(REQ_WRITE, 8'h10, 8'h77));
        send_request(make_word(REQ_READ, 8'h10, 8'h00));
        send_request(make_word(REQ_UNKNOWN, 8'hFF, 8'hFF));
        send_request(make_word(REQ_FLUSH, 8'h00, 8'h00));
        send_request(make_word(REQ_FLUSH, 8'h00, 8'h00));
        send_request(make_word(REQ_FLUSH, 8'h00, 8'h00));
        send_request(make_word(REQ_FLUSH, 8'h00, 8'h00));
        send_request(make_word(REQ_WRITE, 8'h10, 8'h5A));
        send_request(make_word(REQ_FLUSH, 8'h00, 8'h00));

        // Colliding special addresses: device id wins, then the revision value.
        wait_drained();
        write_reg(REG_ADDR_HW_REV, 8'h00);
        write_reg(REG_ADDR_SW_REV, 8'h00);
        send_request(make_word(REQ_READ, 8'h00, 8'h00));
        wait_drained();
        write_reg(REG_ADDR_DEV_ID, 8'h40);
        send_request(make_word(REQ_READ, 8'h00, 8'h00));

        // Entries queued for an address that is remapped before the flush.
        send_request(make_word(REQ_WRITE, 8'h10, 8'h11));
        send_request(make_word(REQ_WRITE, 8'h10, 8'h22));
        wait_drained();
        write_reg(REG_ADDR_CELL, 8'h20);
        send_request(make_word(REQ_READ, 8'h10, 8'h00));
        send_request(make_word(REQ_FLUSH, 8'h00, 8'h00));
        send_request(make_word(REQ_FLUSH, 8'h00, 8'h00));
        send_request(make_word(REQ_READ, 8'h20, 8'h00));

        // A new default reseeds the cell.
        wait_drained();
        write_reg(REG_CELL_DEFAULT, 8'h42);
        send_request(make_word(REQ_READ, 8'h20, 8'h00));

        // Random phases, each under its own register setting.
        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            prev_cell = sb.addr_cell;
            shared    = 8'($urandom_range(0, 255));
            for (r = REG_DEVICE_ID; r <= REG_CELL_DEFAULT; r++) begin
                case (phase % 4)
                    0:       vals[r] = 8'h00;
                    1:       vals[r] = 8'hFF;
                    2:       vals[r] = 8'($urandom_range(0, 255));
                    default: vals[r] = ($urandom_range(0, 1) != 0) ? shared
                                                                   : 8'($urandom_range(0, 255));
                endcase
            end
            for (r = REG_DEVICE_ID; r <= REG_CELL_DEFAULT; r++) write_reg(r[2:0], vals[r]);

            quiet = (phase % 3 == 1);
            sent  = 0;
            while (sent < RANDOM_ITEMS / PHASES) begin
                burst = $urandom_range(1, 16);
                for (k = 0; k < burst && sent < RANDOM_ITEMS / PHASES; k++) begin
                    pick          = $urandom_range(0, 99);
                    w.address     = 8'($urandom_range(0, 255));
                    w.write_value = 8'($urandom_range(0, 255));
                    if (pick < 35) begin
                        w.req_type = REQ_READ;
                        sel        = $urandom_range(0, 9);
                        if (sel < 4)       w.address = sb.addr_cell;
                        else if (sel == 4) w.address = sb.addr_dev_id;
                        else if (sel == 5) w.address = sb.addr_hw_rev;
                        else if (sel == 6) w.address = sb.addr_sw_rev;
                        else if (sel == 7) w.address = prev_cell;
                    end else if (pick < 70) begin
                        w.req_type = REQ_WRITE;
                        if ($urandom_range(0, 9) < 8) w.address = sb.addr_cell;
                    end else if (pick < 95) begin
                        w.req_type = REQ_FLUSH;
                    end else begin
                        w.req_type = REQ_UNKNOWN;
                    end
                    send_request(w);
                    sent++;
                    // Long receiver hold-off while requests keep coming.
                    if (phase == 3 && sent == 40) hold_req = 1'b1;
                end
                idle_cycles(quiet ? 0 : $urandom_range(0, 8));
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
